@@ sv/size_class_free_list_allocator_assert.svh @@
// assertion helpers for the allocator
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SCFLA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCFLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/scfla_pkg.sv @@
`default_nettype none

package scfla_pkg;

   localparam int MAX_CLASS    = 8;
   localparam int PAGE_BYTES   = 4096;
   localparam int CARVE_W      = 8;
   localparam int FREE_W       = 9;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_BAD    = 3'd1;
   localparam logic [2:0] ST_NOPAGE = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_NULL   = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] request_size;
      logic [2:0]  class_index;
      logic [31:0] element_addr;
      logic        page_valid;
      logic [19:0] page_frame;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  class_out;
      logic [31:0] result_addr;
      logic        page_taken;
      logic [8:0]  free_left;
   } rsp_word_type;

   // element size of a class in bytes
   function automatic logic [12:0] class_bytes(input logic [2:0] cls);
      class_bytes = 13'd32 << cls;
   endfunction

   // elements carved from one page
   function automatic logic [CARVE_W-1:0] class_per_page(input logic [2:0] cls);
      class_per_page = 8'd128 >> cls;
   endfunction

endpackage

`default_nettype wire

@@ sv/scfla_stream_if.sv @@
`default_nettype none

interface scfla_stream_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

@@ sv/size_class_free_list_allocator.sv @@
// channel    dir  word           handshake
// req_chan   in   req_word_type  valid/ready
// rsp_chan   out  rsp_word_type  valid/ready
//
// one word accepted per cycle unless stalled; its result passes the input
// register, then the result register with the freed-stack read data
// synchronous reset clears class state at once; no clearing pass, the freed
// stack memory is undefined until written
// a stalled result holds the result register and backs up into the input
// register; req ready drops only when both are full

`default_nettype none

`include "size_class_free_list_allocator_assert.svh"

module size_class_free_list_allocator
   import scfla_pkg::*;
#(
   parameter int CLASS_COUNT = 8,
   parameter int STACK_DEPTH = 256
) (
   input  wire            clock,
   input  wire            reset,
   scfla_stream_if.sink   req_chan,
   scfla_stream_if.source rsp_chan
);

   localparam int MEM_DEPTH = CLASS_COUNT * STACK_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int TOP_W     = $clog2(STACK_DEPTH + 1);
   localparam int TOPX_W    = (TOP_W > FREE_W) ? TOP_W : FREE_W;

   logic                 s1_valid_ff;
   req_word_type         s1_word_ff;
   logic                 s2_valid_ff;
   rsp_word_type         s2_word_ff;
   logic                 s2_stack_ff;
   rsp_word_type         s2_word_in;
   logic                 s2_stack_in;

   logic [TOP_W-1:0]     top_ff   [MAX_CLASS];
   logic [CARVE_W-1:0]   rem_ff   [MAX_CLASS];
   logic [19:0]          page_ff  [MAX_CLASS];
   logic [15:0]          held_ff  [MAX_CLASS];
   logic [TOP_W-1:0]     top_in;
   logic [CARVE_W-1:0]   rem_in;
   logic [19:0]          page_in;
   logic [15:0]          held_in;

   logic [31:0]          mem [MEM_DEPTH];
   logic [31:0]          mem_q_ff;
   logic                 mem_rd;
   logic                 mem_wr;
   logic [ADDR_W-1:0]    mem_addr;

   logic                 s2_load;
   logic                 s1_adv;
   logic [2:0]           idx;
   logic                 upd;

   assign s2_load        = !s2_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && s2_load;
   assign req_chan.ready = !s1_valid_ff || s2_load;

   always_comb begin
      req_word_type       w;
      logic [2:0]         lk_cls;
      logic               lk_hit;
      logic [TOP_W-1:0]   top;
      logic [CARVE_W-1:0] rem;
      logic [TOPX_W-1:0]  top_x;
      logic [11:0]        low_addr;
      logic [19:0]        frame_use;
      logic               class_ok;
      w          = s1_word_ff;
      lk_cls     = 3'd0;
      lk_hit     = 1'b0;
      for (int i = MAX_CLASS - 1; i >= 0; i--) begin
         if (i < CLASS_COUNT && w.request_size <= {3'b000, class_bytes(3'(i))}) begin
            lk_cls = 3'(i);
            lk_hit = 1'b1;
         end
      end
      if (w.request_size == 16'd0) begin
         lk_hit = 1'b0;
      end
      idx        = (w.opcode == OP_LOOKUP) ? lk_cls : w.class_index;
      class_ok   = 32'(w.class_index) < CLASS_COUNT;
      top        = top_ff[idx];
      rem        = rem_ff[idx];
      top_in     = top;
      rem_in     = rem;
      page_in    = page_ff[idx];
      held_in    = held_ff[idx];
      upd        = 1'b0;
      mem_rd     = 1'b0;
      mem_wr     = 1'b0;
      low_addr   = 12'd0;
      frame_use  = page_ff[idx];
      s2_stack_in            = 1'b0;
      s2_word_in.status      = ST_OK;
      s2_word_in.class_out   = idx;
      s2_word_in.result_addr = 32'd0;
      s2_word_in.page_taken  = 1'b0;
      case (w.opcode)
         OP_LOOKUP: begin
            if (!lk_hit) begin
               s2_word_in.status = ST_BAD;
            end
         end
         OP_ALLOC: begin
            if (!class_ok) begin
               s2_word_in.status = ST_BAD;
            end else if (top != '0) begin
               top_in      = top - 1'b1;
               upd         = 1'b1;
               mem_rd      = 1'b1;
               s2_stack_in = 1'b1;
            end else if (rem == '0 && !w.page_valid) begin
               s2_word_in.status = ST_NOPAGE;
            end else begin
               upd = 1'b1;
               if (rem == '0) begin
                  page_in   = w.page_frame;
                  frame_use = w.page_frame;
                  rem_in    = class_per_page(idx) - 1'b1;
                  held_in   = (held_ff[idx] == 16'hFFFF) ? held_ff[idx] : held_ff[idx] + 1'b1;
                  s2_word_in.page_taken = 1'b1;
               end else begin
                  rem_in = rem - 1'b1;
               end
               low_addr = 12'(rem_in) << (4'd5 + {1'b0, idx});
               s2_word_in.result_addr = {frame_use, low_addr};
            end
         end
         OP_FREE: begin
            if (!class_ok) begin
               s2_word_in.status = ST_BAD;
            end else if (w.element_addr == 32'd0) begin
               s2_word_in.status = ST_NULL;
            end else if (32'(top) >= STACK_DEPTH) begin
               s2_word_in.status = ST_FULL;
            end else begin
               top_in = top + 1'b1;
               upd    = 1'b1;
               mem_wr = 1'b1;
            end
         end
         default: begin
            s2_word_in.status    = ST_BAD;
            s2_word_in.class_out = 3'd0;
         end
      endcase
      top_x = TOPX_W'(top_in);
      s2_word_in.free_left = top_x[FREE_W-1:0] + {1'b0, rem_in};
      if (s2_word_in.status == ST_BAD) begin
         s2_word_in.free_left = 9'd0;
      end
      mem_addr = ADDR_W'(32'(idx) * STACK_DEPTH) + ADDR_W'(mem_rd ? top_in : top);
   end

   always_ff @(posedge clock) begin
      if (s1_adv && mem_wr) begin
         mem[mem_addr] <= s1_word_ff.element_addr;
      end
      if (s1_adv && mem_rd) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CLASS; i++) begin
            top_ff[i]  <= '0;
            rem_ff[i]  <= '0;
            page_ff[i] <= '0;
            held_ff[i] <= '0;
         end
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s1_adv && upd) begin
            top_ff[idx]  <= top_in;
            rem_ff[idx]  <= rem_in;
            page_ff[idx] <= page_in;
            held_ff[idx] <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         s1_word_ff <= req_chan.word;
      end
      if (s1_adv) begin
         s2_word_ff  <= s2_word_in;
         s2_stack_ff <= s2_stack_in;
      end
   end

   always_comb begin
      rsp_chan.word = s2_word_ff;
      if (s2_stack_ff) begin
         rsp_chan.word.result_addr = mem_q_ff;
      end
   end
   assign rsp_chan.valid = s2_valid_ff;

   `SCFLA_ASSERT_NOW(a_ready_only_on_backup, clock, reset, !req_chan.ready,
      s1_valid_ff && s2_valid_ff && !rsp_chan.ready, "input stalled without a full pipeline")
   `SCFLA_ASSERT_NEXT(a_push_bumps_top, clock, reset, s1_adv && mem_wr,
      top_ff[$past(idx)] == $past(top_in), "free did not advance the stack top")
   `SCFLA_ASSERT_NEXT(a_page_taken_loads_frame, clock, reset, s1_adv && s2_word_in.page_taken,
      page_ff[$past(idx)] == $past(s1_word_ff.page_frame), "taken page not recorded")

endmodule

`default_nettype wire

@@ tb/sv/allocator_checker.sv @@
module allocator_checker
   import scfla_pkg::*;
#(
   parameter int CLASS_COUNT = 8,
   parameter int STACK_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   output int unsigned  fail_count,
   output int unsigned  pending_count,
   output int unsigned  checked_count
);

   logic [31:0]  freed_mem [CLASS_COUNT][STACK_DEPTH];
   int unsigned  held_count [CLASS_COUNT];
   int unsigned  carve_left [CLASS_COUNT];
   logic [19:0]  carve_frame [CLASS_COUNT];
   rsp_word_type results_due [$];

   function automatic rsp_word_type allocator_result(input req_word_type w);
      rsp_word_type r;
      int cls;
      int i;
      r = '0;
      cls = w.class_index;
      case (w.opcode)
         OP_LOOKUP: begin
            r.status = ST_BAD;
            if (w.request_size != 0) begin
               for (i = CLASS_COUNT - 1; i >= 0; i--) begin
                  if ((32 << i) >= w.request_size) begin
                     r.status = ST_OK;
                     r.class_out = 3'(i);
                  end
               end
               if (r.status == ST_OK)
                  r.free_left = 9'(held_count[r.class_out] + carve_left[r.class_out]);
            end
         end
         OP_ALLOC, OP_FREE: begin
            r.class_out = w.class_index;
            if (cls >= CLASS_COUNT) begin
               r.status = ST_BAD;
            end else begin
               if (w.opcode == OP_ALLOC) begin
                  if (held_count[cls] > 0) begin
                     held_count[cls]--;
                     r.result_addr = freed_mem[cls][held_count[cls]];
                  end else if (carve_left[cls] == 0 && !w.page_valid) begin
                     r.status = ST_NOPAGE;
                  end else begin
                     // carve from the top of the page down
                     if (carve_left[cls] == 0) begin
                        carve_frame[cls] = w.page_frame;
                        carve_left[cls] = (PAGE_BYTES / 32) >> cls;
                        r.page_taken = 1'b1;
                     end
                     carve_left[cls]--;
                     r.result_addr = {carve_frame[cls], 12'h000}
                                   + 32'(carve_left[cls] * (32 << cls));
                  end
               end else begin
                  if (w.element_addr == 0) begin
                     r.status = ST_NULL;
                  end else if (held_count[cls] >= STACK_DEPTH) begin
                     r.status = ST_FULL;
                  end else begin
                     freed_mem[cls][held_count[cls]] = w.element_addr;
                     held_count[cls]++;
                  end
               end
               r.free_left = 9'(held_count[cls] + carve_left[cls]);
            end
         end
         default: begin
            r.status = ST_BAD;
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         results_due.delete();
         foreach (held_count[c]) begin
            held_count[c] = 0;
            carve_left[c] = 0;
            carve_frame[c] = '0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("result word 0x%0h with no request outstanding", rsp_word);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               compare_field("status", want.status, rsp_word.status);
               compare_field("class_out", want.class_out, rsp_word.class_out);
               compare_field("result_addr", want.result_addr, rsp_word.result_addr);
               compare_field("page_taken", want.page_taken, rsp_word.page_taken);
               compare_field("free_left", want.free_left, rsp_word.free_left);
               checked_count++;
            end
         end
         if (req_valid && req_ready)
            results_due.push_back(allocator_result(req_word));
      end
      pending_count = results_due.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
   import scfla_pkg::*;

   localparam int CLASS_COUNT = 8;
   localparam int STACK_DEPTH = 256;
   localparam int RANDOM_WORDS = 950;
   localparam int LONG_HOLD = 200;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;
   bit steady;
   bit long_hold;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned op_count [4];
   int unsigned words_sent;

   scfla_stream_if #(.word_type(req_word_type)) req_chan ();
   scfla_stream_if #(.word_type(rsp_word_type)) rsp_chan ();

   size_class_free_list_allocator #(
      .CLASS_COUNT(CLASS_COUNT),
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   allocator_checker #(
      .CLASS_COUNT(CLASS_COUNT),
      .STACK_DEPTH(STACK_DEPTH)
   ) result_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req_word(req_chan.word),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_word(rsp_chan.word),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   initial clock = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_word_type random_word(input logic [1:0] op, input logic [2:0] cls);
      req_word_type w;
      w.opcode = op;
      w.request_size = 16'($urandom);
      w.class_index = cls;
      w.element_addr = $urandom;
      w.page_valid = 1'($urandom);
      w.page_frame = 20'($urandom);
      return w;
   endfunction

   function automatic logic [15:0] lookup_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 16'($urandom_range(1, PAGE_BYTES));
      if (roll < 80)
         return 16'((32 << $urandom_range(0, 7)) + $urandom_range(0, 2) - 1);
      return 16'($urandom);
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.word <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      op_count[w.opcode]++;
      words_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic alloc_burst(input logic [2:0] cls, input int n, input int page_pct);
      req_word_type w;
      repeat (n) begin
         w = random_word(OP_ALLOC, cls);
         w.page_valid = ($urandom_range(0, 99) < page_pct);
         send_word(w);
      end
   endtask

   task automatic free_burst(input logic [2:0] cls, input int n, input int null_pct);
      req_word_type w;
      repeat (n) begin
         w = random_word(OP_FREE, cls);
         if ($urandom_range(0, 99) < null_pct)
            w.element_addr = '0;
         else if (w.element_addr == 0)
            w.element_addr = 32'h0000_1000;
         send_word(w);
      end
   endtask

   // result side: random stalls, plus one long hold on request
   initial begin
      int stall;
      bit hold_done;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      #4_000_000;
      $display("** size_class_free_list_allocator: FAILED **");
      $finish;
   end

   initial begin
      int directed_sizes [7];
      req_word_type w;
      int seq;
      int roll;
      int n;
      logic [2:0] cls;
      directed_sizes = '{0, 1, 32, 33, 4096, 4097, 65535};
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.word = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // lookups at the size edges, then an unused opcode
      foreach (directed_sizes[i])
         send_word(req_word_type'{OP_LOOKUP, 16'(directed_sizes[i]), 3'd0, 32'd0, 1'b0, 20'd0});
      w = '1;
      w.opcode = OP_UNUSED;
      send_word(w);
      // empty class, fresh page, page ignored while carving
      send_word(req_word_type'{OP_ALLOC, 16'd0, 3'd0, 32'd0, 1'b0, 20'h00000});
      send_word(req_word_type'{OP_ALLOC, 16'hffff, 3'd0, 32'hffff_ffff, 1'b1, 20'hfffff});
      send_word(req_word_type'{OP_ALLOC, 16'd0, 3'd0, 32'd0, 1'b1, 20'h12345});
      send_word(req_word_type'{OP_ALLOC, 16'd0, 3'd7, 32'd0, 1'b1, 20'h00001});
      send_word(req_word_type'{OP_ALLOC, 16'd0, 3'd7, 32'd0, 1'b0, 20'h00000});
      // null free, push and pop back in stack order
      send_word(req_word_type'{OP_FREE, 16'd0, 3'd3, 32'h0000_0000, 1'b0, 20'd0});
      send_word(req_word_type'{OP_FREE, 16'd0, 3'd3, 32'hffff_ffff, 1'b0, 20'd0});
      send_word(req_word_type'{OP_FREE, 16'd0, 3'd3, 32'h0000_0001, 1'b0, 20'd0});
      send_word(req_word_type'{OP_ALLOC, 16'd0, 3'd3, 32'd0, 1'b0, 20'd0});
      send_word(req_word_type'{OP_ALLOC, 16'd0, 3'd3, 32'd0, 1'b0, 20'd0});
      send_word(req_word_type'{OP_ALLOC, 16'd0, 3'd3, 32'd0, 1'b0, 20'd0});
      send_word(req_word_type'{OP_LOOKUP, 16'd256, 3'd0, 32'd0, 1'b0, 20'd0});
      wait_drained();

      // overflow the freed stack of class 0, then pop some back
      steady = 1'b1;
      free_burst(3'd0, STACK_DEPTH + 4, 0);
      steady = 1'b0;
      alloc_burst(3'd0, 6, 50);
      wait_drained();

      // long output stall while input keeps coming
      steady = 1'b1;
      long_hold = 1'b1;
      alloc_burst(3'd2, 40, 90);
      steady = 1'b0;
      wait_drained();

      seq = 0;
      while (words_sent < 25 + RANDOM_WORDS) begin
         seq++;
         steady = (seq % 6 == 0);
         if (seq % 9 == 0)
            wait_drained();
         roll = $urandom_range(0, 99);
         cls = 3'($urandom_range(0, CLASS_COUNT - 1));
         n = $urandom_range(1, 12);
         if (roll < 30) begin
            alloc_burst(cls, n, 80);
         end else if (roll < 55) begin
            free_burst(cls, n, 8);
         end else if (roll < 72) begin
            repeat (n) begin
               w = random_word(OP_LOOKUP, cls);
               w.request_size = lookup_size();
               send_word(w);
            end
         end else if (roll < 90) begin
            repeat (n) begin
               alloc_burst(cls, 1, 70);
               free_burst(3'($urandom_range(0, CLASS_COUNT - 1)), 1, 5);
            end
         end else begin
            repeat (n) send_word(random_word(2'($urandom), 3'($urandom)));
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d words: %0d lookups, %0d allocations, %0d frees, %0d unused opcode",
               words_sent, op_count[OP_LOOKUP], op_count[OP_ALLOC], op_count[OP_FREE],
               op_count[OP_UNUSED]);
      $display("%0d results compared, freed stack overflow and a long output stall included",
               checked_count);
      if (fail_count == 0 && pending_count == 0)
         $display("** size_class_free_list_allocator: PASSED **");
      else
         $display("** size_class_free_list_allocator: FAILED **");
      $finish;
   end

endmodule
